// ----- rtl/core/nipd_pkg.sv -----
// Shared types and constants for the NEC infrared pulse decoder.
// Used by the front stage, the request queue, the back stage and the top level.
package nipd_pkg;

   typedef enum logic [1:0] {
      OP_EDGE = 2'd0,
      OP_TICK = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_EXPECTED_ADDRESS = 3'd0,
      CSR_START_MIN        = 3'd1,
      CSR_START_MAX        = 3'd2,
      CSR_ZERO_MIN         = 3'd3,
      CSR_ZERO_MAX         = 3'd4,
      CSR_ONE_MIN          = 3'd5,
      CSR_ONE_MAX          = 3'd6,
      CSR_RELEASE_TICKS    = 3'd7
   } csr_index_type;

   localparam logic [15:0] REPEAT_LOW   = 16'd4500;
   localparam logic [15:0] REPEAT_HIGH  = 16'd6000;
   localparam logic [5:0]  START_EDGE   = 6'd2;
   localparam logic [5:0]  FRAME_EDGES  = 6'd34;
   localparam logic [5:0]  REPEAT_EDGES = 6'd40;
   localparam logic [7:0]  BYTE_MASK    = 8'hff;

   localparam logic [7:0]  RST_EXPECTED_ADDRESS = 8'd0;
   localparam logic [15:0] RST_START_MIN        = 16'd6000;
   localparam logic [15:0] RST_START_MAX        = 16'd8000;
   localparam logic [15:0] RST_ZERO_MIN         = 16'd450;
   localparam logic [15:0] RST_ZERO_MAX         = 16'd700;
   localparam logic [15:0] RST_ONE_MIN          = 16'd800;
   localparam logic [15:0] RST_ONE_MAX          = 16'd1300;
   localparam logic [1:0]  RST_RELEASE_TICKS    = 2'd2;

   typedef struct packed {
      logic [7:0]  expected_address;
      logic [15:0] start_min;
      logic [15:0] start_max;
      logic [15:0] zero_min;
      logic [15:0] zero_max;
      logic [15:0] one_min;
      logic [15:0] one_max;
      logic [1:0]  release_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       line_level;
      logic       start_ok;
      logic       zero_ok;
      logic       one_ok;
      logic       repeat_ok;
   } item_type;

endpackage

// ----- rtl/core/nipd_front.sv -----
// Front stage: accepts requests, measures pulse widths and classifies them.
// Depends on nipd_pkg for the configuration and queue item types.
module nipd_front
   import nipd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_capture_time,
   input  logic        req_line_level,
   output logic        req_stall,
   input  cfg_type     cfg,
   input  logic        queue_full,
   output logic        push,
   output item_type    push_item
);

   logic [15:0] previous_capture_ff;
   logic [15:0] previous_capture_in;
   logic [15:0] width;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign width     = req_capture_time - previous_capture_ff;

   always_comb begin
      push_item.opcode     = req_opcode;
      push_item.line_level = req_line_level;
      push_item.start_ok   = (width > cfg.start_min) && (width < cfg.start_max);
      push_item.zero_ok    = (width > cfg.zero_min) && (width < cfg.zero_max);
      push_item.one_ok     = (width > cfg.one_min) && (width < cfg.one_max);
      push_item.repeat_ok  = (width > REPEAT_LOW) && (width < REPEAT_HIGH);
   end

   always_comb begin
      previous_capture_in = previous_capture_ff;
      if (push && (opcode_type'(req_opcode) == OP_EDGE)) begin
         previous_capture_in = req_capture_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_capture_ff <= '0;
      end else begin
         previous_capture_ff <= previous_capture_in;
      end
   end

endmodule

// ----- rtl/core/nipd_queue.sv -----
// Short request queue between the front and back stages.
// Depends on nipd_pkg for the queue item type.
module nipd_queue
   import nipd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

   item_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/nipd_back.sv -----
// Back stage: runs the decode state machine on classified requests and
// holds the response register. Depends on nipd_pkg.
module nipd_back
   import nipd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        queue_empty,
   input  item_type    head_item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_key_ready,
   output logic [7:0]  rsp_command_byte,
   output logic [7:0]  rsp_address_byte,
   output logic [7:0]  rsp_repeat_total,
   output logic [1:0]  rsp_phase
);

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_RECEIVING = 2'd1,
      PH_REPEAT    = 2'd2
   } phase_type;

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [31:0] shift_ff;
   logic [31:0] shift_in;
   logic [5:0]  edge_count_ff;
   logic [5:0]  edge_count_in;
   logic [5:0]  edge_next;
   logic        ready_ff;
   logic        ready_in;
   logic [7:0]  address_ff;
   logic [7:0]  address_in;
   logic [7:0]  command_ff;
   logic [7:0]  command_in;
   logic [7:0]  repeat_ff;
   logic [7:0]  repeat_in;
   logic [1:0]  release_ff;
   logic [1:0]  release_in;
   logic        key_out;
   logic        frame_ok;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_key_ready_ff;
   logic [7:0]  rsp_command_ff;
   logic [7:0]  rsp_address_ff;
   logic [7:0]  rsp_repeat_ff;
   logic [1:0]  rsp_phase_ff;

   assign pop       = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign edge_next = edge_count_ff + 6'd1;

   always_comb begin
      phase_in      = phase_ff;
      shift_in      = shift_ff;
      edge_count_in = edge_count_ff;
      ready_in      = ready_ff;
      address_in    = address_ff;
      command_in    = command_ff;
      repeat_in     = repeat_ff;
      release_in    = release_ff;
      frame_ok      = 1'b0;
      key_out       = ready_ff;
      if (pop) begin
         case (opcode_type'(head_item.opcode))
            OP_EDGE: begin
               release_in    = '0;
               edge_count_in = edge_next;
               case (phase_ff)
                  PH_RECEIVING: begin
                     if (edge_next > START_EDGE) begin
                        shift_in = {shift_ff[30:0], 1'b0};
                        if (head_item.zero_ok) begin
                           shift_in[0] = 1'b0;
                        end else if (head_item.one_ok) begin
                           shift_in[0] = 1'b1;
                        end else begin
                           shift_in      = '0;
                           edge_count_in = '0;
                           phase_in      = PH_IDLE;
                           repeat_in     = '0;
                        end
                        if (edge_next == FRAME_EDGES) begin
                           address_in = shift_in[31:24];
                           frame_ok   = ((shift_in[31:24] ^ shift_in[23:16]) == BYTE_MASK)
                                     && ((shift_in[15:8] ^ shift_in[7:0]) == BYTE_MASK)
                                     && (shift_in[31:24] == cfg.expected_address);
                           if (frame_ok) begin
                              command_in = shift_in[15:8];
                              ready_in   = 1'b1;
                              phase_in   = PH_REPEAT;
                           end else begin
                              shift_in      = '0;
                              edge_count_in = '0;
                              phase_in      = PH_IDLE;
                              repeat_in     = '0;
                           end
                        end
                     end
                  end
                  PH_REPEAT: begin
                     if (edge_next == REPEAT_EDGES) begin
                        ready_in      = 1'b1;
                        edge_count_in = FRAME_EDGES;
                        if (head_item.repeat_ok) begin
                           repeat_in = repeat_ff + 8'd1;
                        end
                     end
                  end
                  default: begin
                     if (edge_next == START_EDGE) begin
                        if (head_item.start_ok) begin
                           phase_in = PH_RECEIVING;
                        end else begin
                           shift_in      = '0;
                           edge_count_in = '0;
                           phase_in      = PH_IDLE;
                           repeat_in     = '0;
                        end
                     end
                  end
               endcase
               key_out = ready_in;
            end
            OP_TICK: begin
               if (head_item.line_level) begin
                  if (release_ff != 2'd3) begin
                     release_in = release_ff + 2'd1;
                  end
                  if (release_in >= cfg.release_ticks) begin
                     shift_in      = '0;
                     edge_count_in = '0;
                     phase_in      = PH_IDLE;
                     repeat_in     = '0;
                  end
               end
               key_out = ready_in;
            end
            OP_READ: begin
               ready_in = 1'b0;
            end
            default: begin
               key_out = ready_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         shift_ff      <= '0;
         edge_count_ff <= '0;
         ready_ff      <= 1'b0;
         address_ff    <= '0;
         command_ff    <= '0;
         repeat_ff     <= '0;
         release_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         shift_ff      <= shift_in;
         edge_count_ff <= edge_count_in;
         ready_ff      <= ready_in;
         address_ff    <= address_in;
         command_ff    <= command_in;
         repeat_ff     <= repeat_in;
         release_ff    <= release_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_key_ready_ff <= key_out;
         rsp_command_ff   <= command_in;
         rsp_address_ff   <= address_in;
         rsp_repeat_ff    <= repeat_in;
         rsp_phase_ff     <= phase_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_ready    = rsp_key_ready_ff;
   assign rsp_command_byte = rsp_command_ff;
   assign rsp_address_byte = rsp_address_ff;
   assign rsp_repeat_total = rsp_repeat_ff;
   assign rsp_phase        = rsp_phase_ff;

`ifndef ASSERT_OFF
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (edge_count_ff < START_EDGE))
      else $error("idle phase holds an edge count past the start edge");

   a_receiving_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RECEIVING) |-> (edge_count_ff >= START_EDGE
                                      && edge_count_ff < FRAME_EDGES))
      else $error("receiving phase edge count out of frame range");

   a_repeat_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REPEAT) |-> (edge_count_ff >= FRAME_EDGES
                                   && edge_count_ff < REPEAT_EDGES))
      else $error("repeat phase edge count out of repeat range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("request taken while a stalled response is pending");
`endif

endmodule

// ----- rtl/core/nec_ir_pulse_decoder_top.sv -----
// NEC infrared pulse decoder top level: configuration registers, front stage,
// request queue and back stage. Depends on nipd_pkg and the nipd_* modules.
//
// The block takes one request per clock cycle while its queue is not full and
// gives one response for each request, in order. A request is classified in
// the same cycle it is accepted and written to the queue; the back stage's
// state update takes it from the queue head and registers the response, which
// is offered the next cycle. Sustained throughput is one request per cycle
// while responses are not stalled, set by that state update; from acceptance a
// request passes the queue entry and then the response register before its
// response is valid. The queue holds QUEUE_DEPTH requests, so up to that many
// can be accepted while a response is stalled. Configuration writes are always
// ready and are registered; they are meant for times when no request is in flight.
module nec_ir_pulse_decoder_top
   import nipd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_capture_time,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_key_ready,
   output logic [7:0]  rsp_command_byte,
   output logic [7:0]  rsp_address_byte,
   output logic [7:0]  rsp_repeat_total,
   output logic [1:0]  rsp_phase,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push;
   item_type push_item;
   logic     pop;
   item_type head_item;
   logic     queue_full;
   logic     queue_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_EXPECTED_ADDRESS: cfg_in.expected_address = csr_data[7:0];
            CSR_START_MIN:        cfg_in.start_min        = csr_data;
            CSR_START_MAX:        cfg_in.start_max        = csr_data;
            CSR_ZERO_MIN:         cfg_in.zero_min         = csr_data;
            CSR_ZERO_MAX:         cfg_in.zero_max         = csr_data;
            CSR_ONE_MIN:          cfg_in.one_min          = csr_data;
            CSR_ONE_MAX:          cfg_in.one_max          = csr_data;
            CSR_RELEASE_TICKS:    cfg_in.release_ticks    = csr_data[1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_address <= RST_EXPECTED_ADDRESS;
         cfg_ff.start_min        <= RST_START_MIN;
         cfg_ff.start_max        <= RST_START_MAX;
         cfg_ff.zero_min         <= RST_ZERO_MIN;
         cfg_ff.zero_max         <= RST_ZERO_MAX;
         cfg_ff.one_min          <= RST_ONE_MIN;
         cfg_ff.one_max          <= RST_ONE_MAX;
         cfg_ff.release_ticks    <= RST_RELEASE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nipd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_opcode       (req_opcode),
      .req_capture_time (req_capture_time),
      .req_line_level   (req_line_level),
      .req_stall        (req_stall),
      .cfg              (cfg_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   nipd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   nipd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .queue_empty      (queue_empty),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_ready    (rsp_key_ready),
      .rsp_command_byte (rsp_command_byte),
      .rsp_address_byte (rsp_address_byte),
      .rsp_repeat_total (rsp_repeat_total),
      .rsp_phase        (rsp_phase)
   );

endmodule
